@@ rtl/lpfb_pkg.sv @@
`default_nettype none
package lpfb_pkg;

  // Fixed field widths
  localparam int MAX_PIXELS_DEF = 64;
  localparam int COUNT_W        = 7;
  localparam int BYTE_W         = 8;
  localparam int PIXEL_W        = 3 * BYTE_W;
  localparam int INDEX_IN_W     = 16;
  localparam int STEPS_W        = 16;
  localparam int KIND_W         = 2;
  localparam int CFG_DATA_W     = 8;
  localparam int CFG_INDEX_W    = 1;
  localparam int PROD_W         = 2 * BYTE_W;

  // Register reset values
  localparam logic [COUNT_W-1:0] PIXEL_COUNT_RESET = 7'd64;
  localparam logic [BYTE_W-1:0]  BRIGHTNESS_RESET  = 8'd255;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_COUNT = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_BRIGHTNESS  = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_SET    = 2'd0,
    KIND_FILL   = 2'd1,
    KIND_ROTATE = 2'd2,
    KIND_SHOW   = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SET,
    S_FILL_WR,
    S_FILL_WAIT,
    S_SHOW_RD,
    S_SHOW_MUL,
    S_SHOW_LOAD,
    S_SHOW_WAIT,
    S_ROT_START,
    S_ROT_WAIT,
    S_ROT_RD,
    S_ROT_WR1,
    S_ROT_RD2,
    S_ROT_WR2
  } state_t;

  // Exact floor(x / 255) for x below 65280, which covers every product of two
  // bytes: reciprocal with a carry correction
  function automatic logic [BYTE_W-1:0] div255(input logic [PROD_W-1:0] x);
    logic [PROD_W:0] sum;
    sum = {1'b0, x} + {{(BYTE_W + 1){1'b0}}, x[PROD_W-1:BYTE_W]} + 1'b1;
    return sum[PROD_W-1:BYTE_W];
  endfunction

endpackage
`default_nettype wire

@@ rtl/lpfb_mod_unit.sv @@
`default_nettype none
module lpfb_mod_unit import lpfb_pkg::*; #(
  parameter int CNT_W = 7
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [STEPS_W-1:0] dividend,
  input  wire logic [CNT_W-1:0]   divisor,
  output logic                    busy,
  output logic [CNT_W-1:0]        remainder
);

  localparam int ITER_W = $clog2(STEPS_W);

  logic [STEPS_W-1:0] shift;
  logic [CNT_W-1:0]   dvs;
  logic [ITER_W-1:0]  iter;
  logic [CNT_W:0]     trial;
  logic [CNT_W:0]     rem_next;

  // One restoring step: bring down a bit, subtract when it fits
  always_comb begin
    trial = {remainder, shift[STEPS_W-1]};
    if (trial >= {1'b0, dvs}) begin
      rem_next = trial - {1'b0, dvs};
    end else begin
      rem_next = trial;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      iter <= '0;
    end else if (start) begin
      busy <= 1'b1;
      iter <= '0;
    end else if (busy) begin
      iter <= iter + 1'b1;
      if (iter == ITER_W'(STEPS_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Hold operands and the running remainder
  always_ff @(posedge clk) begin
    if (start) begin
      shift     <= dividend;
      dvs       <= divisor;
      remainder <= '0;
    end else if (busy) begin
      shift     <= {shift[STEPS_W-2:0], 1'b0};
      remainder <= rem_next[CNT_W-1:0];
    end
  end

endmodule
`default_nettype wire

@@ rtl/lpfb_scale_unit.sv @@
`default_nettype none
module lpfb_scale_unit import lpfb_pkg::*; (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic [PIXEL_W-1:0] pixel,
  input  wire logic [BYTE_W-1:0]  level,
  output logic [BYTE_W-1:0]       scaled_green,
  output logic [BYTE_W-1:0]       scaled_red,
  output logic [BYTE_W-1:0]       scaled_blue
);

  logic [PROD_W-1:0] prod_green;
  logic [PROD_W-1:0] prod_red;
  logic [PROD_W-1:0] prod_blue;

  // Register the byte products
  always_ff @(posedge clk) begin
    if (en) begin
      prod_green <= pixel[3*BYTE_W-1:2*BYTE_W] * level;
      prod_red   <= pixel[2*BYTE_W-1:BYTE_W] * level;
      prod_blue  <= pixel[BYTE_W-1:0] * level;
    end
  end

  // Divide each product by full scale
  assign scaled_green = div255(prod_green);
  assign scaled_red   = div255(prod_red);
  assign scaled_blue  = div255(prod_blue);

endmodule
`default_nettype wire

@@ rtl/lpfb_store.sv @@
`default_nettype none
module lpfb_store import lpfb_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int IDX_W = 6
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               we,
  input  wire logic [IDX_W-1:0]   waddr,
  input  wire logic [PIXEL_W-1:0] wdata,
  input  wire logic [IDX_W-1:0]   raddr,
  output logic [PIXEL_W-1:0]      rdata
);

  logic [PIXEL_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]   valid;

  // Mark written entries; reset makes every entry read as black
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= valid[raddr] ? mem[raddr] : '0;
  end

endmodule
`default_nettype wire

@@ rtl/led_pixel_frame_buffer.sv @@
// Frame buffer for an addressable RGB LED strip, pixels held in green, red,
// blue byte order.
// Input channel (in_valid / in_stall) carries one operation per transaction:
// set pixel, fill, rotate or show. in_stall is high while an operation runs;
// the block takes one operation at a time.
// Output channel (out_valid / out_stall) carries one pixel per transaction,
// index 0 first, last_pixel high on the final one. Fill streams the new
// color unscaled; show streams the store scaled by brightness/255.
// Set pixel writes one entry; fill writes and streams each pixel; show reads,
// multiplies and divides each pixel into the output register; rotate runs the
// 16-step remainder unit, then copies to a scratch memory and back unless the
// rotation is a multiple of the active pixel count. A stalled output holds its
// pixel and the walk waits on it. Configuration (cfg_write, cfg_index,
// cfg_data) must be written only while idle; the block does not enforce this.
// Reset (rst, synchronous) clears the store to black, sets pixel_count to 64
// and brightness to 255, and drops any transaction in flight.
`default_nettype none
module led_pixel_frame_buffer import lpfb_pkg::*; #(
  parameter int MAX_PIXELS = MAX_PIXELS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [KIND_W-1:0]      kind,
  input  wire logic [INDEX_IN_W-1:0]  pixel_index,
  input  wire logic [BYTE_W-1:0]      red,
  input  wire logic [BYTE_W-1:0]      green,
  input  wire logic [BYTE_W-1:0]      blue,
  input  wire logic [STEPS_W-1:0]     rotate_steps,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [BYTE_W-1:0]           out_green,
  output logic [BYTE_W-1:0]           out_red,
  output logic [BYTE_W-1:0]           out_blue,
  output logic                        last_pixel
);

  localparam int IDX_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int CNT_W = $clog2(MAX_PIXELS + 1);

  state_t state, state_next;

  logic [COUNT_W-1:0]    pixel_count;
  logic [BYTE_W-1:0]     brightness;
  logic [CNT_W-1:0]      active;
  logic [CNT_W-1:0]      last_idx;

  logic [INDEX_IN_W-1:0] op_index;
  logic [PIXEL_W-1:0]    op_color;
  logic [STEPS_W-1:0]    op_steps;

  logic [IDX_W-1:0]      cnt;
  logic                  is_last;
  logic                  in_take;
  logic                  out_take;

  logic                  st_we;
  logic [IDX_W-1:0]      st_waddr;
  logic [PIXEL_W-1:0]    st_wdata;
  logic [IDX_W-1:0]      st_raddr;
  logic [PIXEL_W-1:0]    st_rdata;
  logic [IDX_W-1:0]      set_addr;
  logic [IDX_W-1:0]      rot_src;
  logic [CNT_W:0]        rot_sum;

  logic [PIXEL_W-1:0]    scratch [MAX_PIXELS];
  logic [PIXEL_W-1:0]    scratch_q;
  logic                  scr_we;

  logic                  mod_start;
  logic                  mod_busy;
  logic [CNT_W-1:0]      mod_rem;

  logic                  scale_en;
  logic [BYTE_W-1:0]     scaled_green;
  logic [BYTE_W-1:0]     scaled_red;
  logic [BYTE_W-1:0]     scaled_blue;

  logic                  load_fill;
  logic                  load_show;
  logic                  cnt_clr;
  logic                  cnt_inc;

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_count <= PIXEL_COUNT_RESET;
      brightness  <= BRIGHTNESS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PIXEL_COUNT: pixel_count <= cfg_data[COUNT_W-1:0];
        REG_BRIGHTNESS:  brightness  <= cfg_data[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the count into one to the store depth
  always_comb begin
    if (pixel_count == '0) begin
      active = CNT_W'(1);
    end else if (pixel_count > COUNT_W'(MAX_PIXELS)) begin
      active = CNT_W'(MAX_PIXELS);
    end else begin
      active = CNT_W'(pixel_count);
    end
    last_idx = active - 1'b1;
    is_last  = (CNT_W'(cnt) == last_idx);
  end

  // Clamp the set index; wrap the rotate source index
  always_comb begin
    if (op_index >= INDEX_IN_W'(active)) begin
      set_addr = IDX_W'(last_idx);
    end else begin
      set_addr = IDX_W'(op_index);
    end
    rot_sum = (CNT_W + 1)'(cnt) + (CNT_W + 1)'(mod_rem);
    if (rot_sum >= (CNT_W + 1)'(active)) begin
      rot_src = IDX_W'(rot_sum - (CNT_W + 1)'(active));
    end else begin
      rot_src = IDX_W'(rot_sum);
    end
  end

  // Capture the operation
  always_ff @(posedge clk) begin
    if (in_take) begin
      op_index <= pixel_index;
      op_color <= {green, red, blue};
      op_steps <= rotate_steps;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (kind_t'(kind))
            KIND_SET:    state_next = S_SET;
            KIND_FILL:   state_next = S_FILL_WR;
            KIND_ROTATE: state_next = S_ROT_START;
            KIND_SHOW:   state_next = S_SHOW_RD;
            default:     state_next = S_IDLE;
          endcase
        end
      end
      S_SET:       state_next = S_IDLE;
      S_FILL_WR:   state_next = S_FILL_WAIT;
      S_FILL_WAIT: begin
        if (out_take) begin
          state_next = is_last ? S_IDLE : S_FILL_WR;
        end
      end
      S_SHOW_RD:   state_next = S_SHOW_MUL;
      S_SHOW_MUL:  state_next = S_SHOW_LOAD;
      S_SHOW_LOAD: state_next = S_SHOW_WAIT;
      S_SHOW_WAIT: begin
        if (out_take) begin
          state_next = is_last ? S_IDLE : S_SHOW_RD;
        end
      end
      S_ROT_START: state_next = S_ROT_WAIT;
      S_ROT_WAIT: begin
        if (!mod_busy) begin
          state_next = (mod_rem == '0) ? S_IDLE : S_ROT_RD;
        end
      end
      S_ROT_RD:    state_next = S_ROT_WR1;
      S_ROT_WR1:   state_next = is_last ? S_ROT_RD2 : S_ROT_RD;
      S_ROT_RD2:   state_next = S_ROT_WR2;
      S_ROT_WR2:   state_next = is_last ? S_IDLE : S_ROT_RD2;
      default:     state_next = S_IDLE;
    endcase
  end

  // Datapath controls
  always_comb begin
    st_we     = 1'b0;
    st_waddr  = cnt;
    st_wdata  = op_color;
    st_raddr  = cnt;
    scr_we    = 1'b0;
    mod_start = 1'b0;
    scale_en  = 1'b0;
    load_fill = 1'b0;
    load_show = 1'b0;
    cnt_clr   = 1'b0;
    cnt_inc   = 1'b0;
    case (state)
      S_IDLE: cnt_clr = 1'b1;
      S_SET: begin
        st_we    = 1'b1;
        st_waddr = set_addr;
      end
      S_FILL_WR: begin
        st_we     = 1'b1;
        load_fill = 1'b1;
      end
      S_FILL_WAIT: cnt_inc = out_take && !is_last;
      S_SHOW_RD:   ;
      S_SHOW_MUL:  scale_en  = 1'b1;
      S_SHOW_LOAD: load_show = 1'b1;
      S_SHOW_WAIT: cnt_inc = out_take && !is_last;
      S_ROT_START: mod_start = 1'b1;
      S_ROT_WAIT:  cnt_clr = 1'b1;
      S_ROT_RD:    st_raddr = rot_src;
      S_ROT_WR1: begin
        scr_we  = 1'b1;
        cnt_clr = is_last;
        cnt_inc = !is_last;
      end
      S_ROT_RD2:   ;
      S_ROT_WR2: begin
        st_we    = 1'b1;
        st_wdata = scratch_q;
        cnt_inc  = !is_last;
      end
      default: ;
    endcase
  end

  // Walk the pixel index
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cnt_clr) begin
      cnt <= '0;
    end else if (cnt_inc) begin
      cnt <= cnt + 1'b1;
    end
  end

  // Scratch copy for rotate
  always_ff @(posedge clk) begin
    if (scr_we) begin
      scratch[cnt] <= st_rdata;
    end
    scratch_q <= scratch[cnt];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_fill || load_show) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_fill) begin
      out_green  <= op_color[3*BYTE_W-1:2*BYTE_W];
      out_red    <= op_color[2*BYTE_W-1:BYTE_W];
      out_blue   <= op_color[BYTE_W-1:0];
      last_pixel <= is_last;
    end else if (load_show) begin
      out_green  <= scaled_green;
      out_red    <= scaled_red;
      out_blue   <= scaled_blue;
      last_pixel <= is_last;
    end
  end

  lpfb_store #(
    .DEPTH (MAX_PIXELS),
    .IDX_W (IDX_W)
  ) u_store (
    .clk   (clk),
    .rst   (rst),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  lpfb_mod_unit #(
    .CNT_W (CNT_W)
  ) u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (op_steps),
    .divisor   (active),
    .busy      (mod_busy),
    .remainder (mod_rem)
  );

  lpfb_scale_unit u_scale (
    .clk          (clk),
    .en           (scale_en),
    .pixel        (st_rdata),
    .level        (brightness),
    .scaled_green (scaled_green),
    .scaled_red   (scaled_red),
    .scaled_blue  (scaled_blue)
  );

endmodule
`default_nettype wire

@@ tb/sv/led_pixel_frame_buffer_tb.sv @@
`default_nettype none
module led_pixel_frame_buffer_tb;
  import lpfb_pkg::*;

  localparam int CYCLE_LIMIT   = 3_000_000;
  localparam int SETTLE_CYCLES = 300;
  localparam int MAX_SHOWN     = 30;

  // one streamed pixel as the strip would receive it
  typedef struct packed {
    logic [BYTE_W-1:0] g;
    logic [BYTE_W-1:0] r;
    logic [BYTE_W-1:0] b;
    logic              last;
  } led_beat_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [KIND_W-1:0]      kind = '0;
  logic [INDEX_IN_W-1:0]  pixel_index = '0;
  logic [BYTE_W-1:0]      red = '0;
  logic [BYTE_W-1:0]      green = '0;
  logic [BYTE_W-1:0]      blue = '0;
  logic [STEPS_W-1:0]     rotate_steps = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [BYTE_W-1:0]      out_green;
  logic [BYTE_W-1:0]      out_red;
  logic [BYTE_W-1:0]      out_blue;
  logic                   last_pixel;

  // shadow copy of the strip store and registers
  logic [PIXEL_W-1:0] shadow_grb [MAX_PIXELS_DEF];
  logic [COUNT_W-1:0] count_reg = PIXEL_COUNT_RESET;
  logic [BYTE_W-1:0]  bright_reg = BRIGHTNESS_RESET;
  led_beat_t          pending_pixels [$];

  int  mismatches = 0;
  int  pixels_checked = 0;
  int  cfg_writes = 0;
  int  ops_sent [4] = '{0, 0, 0, 0};
  int  cycle_count = 0;
  bit  quiet = 1'b0;
  int  stall_left = 0;

  led_pixel_frame_buffer #(.MAX_PIXELS(MAX_PIXELS_DEF)) DUT (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .pixel_index(pixel_index),
    .red(red), .green(green), .blue(blue), .rotate_steps(rotate_steps),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_green(out_green), .out_red(out_red), .out_blue(out_blue),
    .last_pixel(last_pixel)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("led_pixel_frame_buffer_tb NOT OK");
    $finish;
  end

  // active pixel count as the block sees it: 0 acts as 1, clamp above max
  function automatic int live_count();
    if (count_reg == 0) return 1;
    if (count_reg > MAX_PIXELS_DEF) return MAX_PIXELS_DEF;
    return int'(count_reg);
  endfunction

  function automatic void queue_frame(bit scaled);
    int n;
    led_beat_t beat;
    logic [PIXEL_W-1:0] p;
    n = live_count();
    for (int i = 0; i < n; i++) begin
      p = shadow_grb[i];
      if (scaled) begin
        beat.g = BYTE_W'(int'(p[23:16]) * int'(bright_reg) / 255);
        beat.r = BYTE_W'(int'(p[15:8]) * int'(bright_reg) / 255);
        beat.b = BYTE_W'(int'(p[7:0]) * int'(bright_reg) / 255);
      end else begin
        beat.g = p[23:16];
        beat.r = p[15:8];
        beat.b = p[7:0];
      end
      beat.last = (i == n - 1);
      pending_pixels.push_back(beat);
    end
  endfunction

  // update the shadow store for one operation and queue its pixels
  function automatic void apply_led_op(kind_t op, logic [15:0] idx, logic [7:0] r,
                                       logic [7:0] g, logic [7:0] b, logic [15:0] steps);
    int n;
    int slot;
    int shift;
    logic [PIXEL_W-1:0] rotated [MAX_PIXELS_DEF];
    n = live_count();
    case (op)
      KIND_SET: begin
        slot = (int'(idx) >= n) ? n - 1 : int'(idx);
        shadow_grb[slot] = {g, r, b};
      end
      KIND_FILL: begin
        for (int i = 0; i < n; i++) shadow_grb[i] = {g, r, b};
        queue_frame(1'b0);
      end
      KIND_ROTATE: begin
        shift = int'(steps) % n;
        if (shift != 0) begin
          for (int i = 0; i < n; i++) rotated[i] = shadow_grb[(i + shift) % n];
          for (int i = 0; i < n; i++) shadow_grb[i] = rotated[i];
        end
      end
      default: queue_frame(1'b1);
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [7:0] want, logic [7:0] got);
    if (mismatches < MAX_SHOWN)
      $display("pixel %0d: %s expected %02h got %02h", pixels_checked, what, want, got);
    mismatches++;
  endtask

  // compare each accepted pixel with the oldest expected one
  always @(posedge clk) begin : pixel_check
    led_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected transaction, green", 8'h00, out_green);
      end else begin
        want = pending_pixels.pop_front();
        if (out_green !== want.g) report_mismatch("green", want.g, out_green);
        if (out_red !== want.r) report_mismatch("red", want.r, out_red);
        if (out_blue !== want.b) report_mismatch("blue", want.b, out_blue);
        if (last_pixel !== want.last)
          report_mismatch("last_pixel", 8'(want.last), 8'(last_pixel));
      end
      pixels_checked++;
    end
  end

  // output backpressure: mostly short bursts, now and then a long stall
  always @(posedge clk) begin : stall_gen
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (quiet) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (roll < 65) begin
      out_stall <= 1'b0;
      stall_left <= $urandom_range(0, 7);
    end else if (roll < 95) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(10, 30);
    end
  end

  function automatic int next_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  function automatic logic [7:0] rand_byte();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 8'h00;
    if (roll == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  // offer one operation and hold it until the block takes it
  task automatic send_op(kind_t op, logic [15:0] idx, logic [7:0] r, logic [7:0] g,
                         logic [7:0] b, logic [15:0] steps);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    kind         <= op;
    pixel_index  <= idx;
    red          <= r;
    green        <= g;
    blue         <= b;
    rotate_steps <= steps;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_led_op(op, idx, r, g, b, steps);
    ops_sent[int'(op)]++;
  endtask

  // hold off the input until every queued pixel has been seen
  task automatic wait_for_frames();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_pixels.size() != 0);
  endtask

  // rotate and set give no pixels, so let a running operation finish too
  task automatic settle_block();
    wait_for_frames();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    settle_block();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_PIXEL_COUNT) count_reg = data[COUNT_W-1:0];
    else if (idx == REG_BRIGHTNESS) bright_reg = data;
    cfg_writes++;
  endtask

  // the store comes out of reset black at full count and brightness
  task automatic test_power_on_black();
    send_op(KIND_SHOW, 16'h0000, 8'h00, 8'h00, 8'h00, 16'h0000);
  endtask

  // corner indexes, an index far past the end, full and alternating bytes
  task automatic test_set_pixel_edges();
    send_op(KIND_SET, 16'h0000, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
    send_op(KIND_SET, 16'hFFFF, 8'h12, 8'h34, 8'h56, 16'h0000);
    send_op(KIND_SET, 16'h0020, 8'hAA, 8'h55, 8'hAA, 16'hAAAA);
    send_op(KIND_SET, 16'h003E, 8'h55, 8'hAA, 8'h55, 16'h5555);
    send_op(KIND_SHOW, 16'h0000, 8'h00, 8'h00, 8'h00, 16'h0000);
  endtask

  // fill streams the new color unscaled, then a set on top of it
  task automatic test_fill_stream();
    send_op(KIND_FILL, 16'hFFFF, 8'h5A, 8'hA5, 8'h0F, 16'h0000);
    send_op(KIND_SET, 16'h0001, 8'h01, 8'h80, 8'hF0, 16'h0000);
    send_op(KIND_SHOW, 16'h0000, 8'h00, 8'h00, 8'h00, 16'h0000);
  endtask

  // zero, whole-count and odd rotations
  task automatic test_rotate_cases();
    send_op(KIND_SET, 16'h0000, 8'h01, 8'h02, 8'h03, 16'h0000);
    send_op(KIND_SET, 16'h0005, 8'h04, 8'h05, 8'h06, 16'h0000);
    send_op(KIND_ROTATE, 16'h0000, 8'h00, 8'h00, 8'h00, 16'h0000);
    send_op(KIND_ROTATE, 16'h0000, 8'h00, 8'h00, 8'h00, 16'd64);
    send_op(KIND_ROTATE, 16'h0000, 8'h00, 8'h00, 8'h00, 16'd1);
    send_op(KIND_ROTATE, 16'h0000, 8'h00, 8'h00, 8'h00, 16'hFFFF);
    send_op(KIND_SHOW, 16'h0000, 8'h00, 8'h00, 8'h00, 16'h0000);
  endtask

  // count at one, zero and above max; brightness extremes; inactive entries
  task automatic test_count_and_brightness();
    write_reg(REG_PIXEL_COUNT, 8'd1);
    send_op(KIND_SET, 16'h0009, 8'hC3, 8'h3C, 8'h99, 16'h0000);
    send_op(KIND_ROTATE, 16'h0000, 8'h00, 8'h00, 8'h00, 16'd7);
    send_op(KIND_SHOW, 16'h0000, 8'h00, 8'h00, 8'h00, 16'h0000);
    write_reg(REG_PIXEL_COUNT, 8'd0);
    send_op(KIND_FILL, 16'h0000, 8'h77, 8'h88, 8'h99, 16'h0000);
    write_reg(REG_PIXEL_COUNT, 8'hFF);
    write_reg(REG_BRIGHTNESS, 8'd0);
    send_op(KIND_SHOW, 16'h0000, 8'h00, 8'h00, 8'h00, 16'h0000);
    write_reg(REG_BRIGHTNESS, 8'd1);
    send_op(KIND_SHOW, 16'h0000, 8'h00, 8'h00, 8'h00, 16'h0000);
    write_reg(REG_PIXEL_COUNT, 8'd5);
    write_reg(REG_BRIGHTNESS, 8'd128);
    send_op(KIND_FILL, 16'h0000, 8'hFE, 8'h7F, 8'h80, 16'h0000);
    send_op(KIND_ROTATE, 16'h0000, 8'h00, 8'h00, 8'h00, 16'd2);
    write_reg(REG_PIXEL_COUNT, 8'd100);
    write_reg(REG_BRIGHTNESS, 8'd254);
    send_op(KIND_SHOW, 16'h0000, 8'h00, 8'h00, 8'h00, 16'h0000);
  endtask

  task automatic run_random_phase(logic [7:0] count_val, logic [7:0] bright_val, int items);
    int unsigned roll;
    int n;
    kind_t op;
    logic [15:0] idx;
    logic [15:0] steps;
    write_reg(REG_PIXEL_COUNT, count_val);
    write_reg(REG_BRIGHTNESS, bright_val);
    repeat (items) begin
      n = live_count();
      roll = $urandom_range(0, 99);
      op = (roll < 40) ? KIND_SET : (roll < 55) ? KIND_FILL :
           (roll < 75) ? KIND_ROTATE : KIND_SHOW;
      idx = $urandom_range(0, 1) ? 16'($urandom_range(0, n - 1)) : 16'($urandom);
      steps = $urandom_range(0, 1) ? 16'($urandom_range(0, 2 * n)) : 16'($urandom);
      // occasionally drain the output before offering more work
      if ($urandom_range(0, 24) == 0) wait_for_frames();
      send_op(op, idx, rand_byte(), rand_byte(), rand_byte(), steps);
    end
  endtask

  // mixed traffic across counts and brightness levels, mostly small strips
  task automatic test_random_traffic();
    run_random_phase(8'd64, 8'd255, 20);
    run_random_phase(8'd7, 8'd128, 25);
    run_random_phase(8'd1, 8'd0, 20);
    run_random_phase(8'd0, 8'd77, 20);
    quiet = 1'b1;
    run_random_phase(8'd33, 8'd255, 20);
    quiet = 1'b0;
    run_random_phase(8'hFF, 8'd1, 20);
    run_random_phase(8'd12, 8'($urandom), 25);
    run_random_phase(8'd3, 8'd254, 20);
    run_random_phase(8'd100, 8'($urandom), 20);
    run_random_phase(8'd5, 8'd200, 15);
  endtask

  initial begin
    for (int i = 0; i < MAX_PIXELS_DEF; i++) shadow_grb[i] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_power_on_black();
    test_set_pixel_edges();
    test_fill_stream();
    test_rotate_cases();
    test_count_and_brightness();
    test_random_traffic();
    settle_block();
    $display("Sent %0d set, %0d fill, %0d rotate and %0d show operations, %0d register writes",
             ops_sent[0], ops_sent[1], ops_sent[2], ops_sent[3], cfg_writes);
    $display("Compared %0d streamed pixels field by field, %0d mismatches",
             pixels_checked, mismatches);
    if (mismatches == 0)
      $display("led_pixel_frame_buffer_tb OK");
    else
      $display("led_pixel_frame_buffer_tb NOT OK");
    $finish;
  end

endmodule
`default_nettype wire
